// ----- rtl/core/sgm_pkg.sv -----
// ----------------------------------------------------------------------------
// sgm_pkg
// Types and codes shared by the star glob matcher modules.
// ----------------------------------------------------------------------------
package sgm_pkg;

   typedef logic [7:0] sgm_byte_type;

   // opcode values
   localparam logic OP_PATTERN   = 1'b0;
   localparam logic OP_CANDIDATE = 1'b1;

   // result kinds
   localparam logic KIND_CLASSIFY = 1'b0;
   localparam logic KIND_VERDICT  = 1'b1;

   // special bytes
   localparam sgm_byte_type CH_STAR = 8'h2A;
   localparam sgm_byte_type CH_ESC  = 8'h5C;
   localparam sgm_byte_type CH_NUL  = 8'h00;

   typedef struct packed {
      logic result_kind;
      logic has_star;
      logic star_end_only;
      logic matched;
      logic overflow;
   } sgm_rsp_type;

   // element store write from the parser
   typedef struct packed {
      logic en;
      logic star;
      logic clear;
   } sgm_wr_type;

   // pattern status seen by the verdict logic
   typedef struct packed {
      logic has_star;
      logic star_end_only;
      logic broken;
      logic too_long;
      logic escape;
   } sgm_pat_state_type;

   // broadcast to every cell
   typedef struct packed {
      logic         advance;
      logic         clear;
      sgm_byte_type data_byte;
   } sgm_cell_ctrl_type;

endpackage

// ----- rtl/core/sgm_req_if.sv -----
// ----------------------------------------------------------------------------
// sgm_req_if
// Request channel: pattern or candidate bytes with valid/ready.
// ----------------------------------------------------------------------------
interface sgm_req_if;
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   sgm_pkg::sgm_byte_type data_byte;
   logic                 last;

   modport source (output valid, output opcode, output data_byte, output last,
                   input ready);
   modport sink   (input valid, input opcode, input data_byte, input last,
                   output ready);
endinterface

// ----- rtl/core/sgm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sgm_rsp_if
// Response channel: classification or match verdict with valid/ready.
// ----------------------------------------------------------------------------
interface sgm_rsp_if;
   logic valid;
   logic ready;
   logic result_kind;
   logic has_star;
   logic star_end_only;
   logic matched;
   logic overflow;

   modport source (output valid, output result_kind, output has_star,
                   output star_end_only, output matched, output overflow,
                   input ready);
   modport sink   (input valid, input result_kind, input has_star,
                   input star_end_only, input matched, input overflow,
                   output ready);
endinterface

// ----- rtl/core/sgm_cell.sv -----
// ----------------------------------------------------------------------------
// sgm_cell
// One pattern element: its byte, its star mark and the active bit of its
// position. Hands a match to the next position on each advancing candidate byte.
// ----------------------------------------------------------------------------
module sgm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  sgm_pkg::sgm_cell_ctrl_type ctrl,
   input  logic                       wr_sel,
   input  logic                       wr_star,
   input  logic                       in_use,
   input  logic                       origin,
   input  logic                       pass_in,
   input  logic                       act_in,
   output logic                       star_nx,
   output logic                       adv,
   output logic                       pass_out
);

   sgm_pkg::sgm_byte_type elem_char_ff;
   logic                  star_ff;
   logic                  act_ff;

   // a write wins over the clear of a new pattern
   assign star_nx  = wr_sel ? wr_star : (ctrl.clear ? 1'b0 : star_ff);

   assign pass_out = ctrl.advance & in_use & act_ff & ~star_ff
                     & (elem_char_ff == ctrl.data_byte);

   // a star stays active, a literal moves on to the right
   assign adv = ctrl.advance ? ((act_ff & star_ff) | pass_in) : act_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         star_ff <= 1'b0;
         act_ff  <= origin;
      end else begin
         star_ff <= star_nx;
         act_ff  <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         elem_char_ff <= ctrl.data_byte;
      end
   end

endmodule

// ----- rtl/core/sgm_closure.sv -----
// ----------------------------------------------------------------------------
// sgm_closure
// Spreads active positions across runs of stars: a position right after an
// active star becomes active. Log-depth prefix network.
// ----------------------------------------------------------------------------
module sgm_closure #(
   parameter int WIDTH = 2
) (
   input  logic [WIDTH-1:0] vec,
   input  logic [WIDTH-2:0] star,
   output logic [WIDTH-1:0] closed
);

   localparam int STAGES = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic [WIDTH-1:0] gen  [0:STAGES];
   logic [WIDTH-1:0] prop [0:STAGES];

   always_comb begin
      gen[0]  = vec;
      // prop bit i: activity may flow from position i-1 into i
      prop[0] = {star, 1'b0};
      for (int s = 0; s < STAGES; s++) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (i >= (1 << s)) begin
               gen[s+1][i]  = gen[s][i] | (prop[s][i] & gen[s][i-(1 << s)]);
               prop[s+1][i] = prop[s][i] & prop[s][i-(1 << s)];
            end else begin
               gen[s+1][i]  = gen[s][i];
               prop[s+1][i] = prop[s][i];
            end
         end
      end
   end

   assign closed = gen[STAGES];

endmodule

// ----- rtl/core/sgm_parser.sv -----
// ----------------------------------------------------------------------------
// sgm_parser
// Parses raw pattern bytes into elements: escapes, stars, NUL end, overflow.
// Keeps the element count and the pattern flags.
// ----------------------------------------------------------------------------
module sgm_parser #(
   parameter int PATTERN_MAX = 64,
   localparam int CW = $clog2(PATTERN_MAX + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pat_accept,
   input  sgm_pkg::sgm_byte_type      data_byte,
   input  logic                       last,
   output logic [CW-1:0]              count,
   output logic [CW-1:0]              wr_addr,
   output sgm_pkg::sgm_wr_type        wr,
   output sgm_pkg::sgm_pat_state_type pat_state,
   output sgm_pkg::sgm_rsp_type       pat_rsp
);

   logic [CW-1:0] count_ff,    count_in;
   logic          esc_ff,      esc_in;
   logic          broken_ff,   broken_in;
   logic          ended_ff,    ended_in;
   logic          has_star_ff, has_star_in;
   logic          star_end_ff, star_end_in;
   logic          too_long_ff, too_long_in;
   logic          closed_ff,   closed_in;
   logic          append;

   always_comb begin
      count_in    = count_ff;
      esc_in      = esc_ff;
      broken_in   = broken_ff;
      ended_in    = ended_ff;
      has_star_in = has_star_ff;
      star_end_in = star_end_ff;
      too_long_in = too_long_ff;
      closed_in   = closed_ff;
      append      = 1'b0;
      wr          = '0;
      wr_addr     = count_ff;
      if (pat_accept) begin
         // first byte after a finished pattern starts a new one
         if (closed_ff) begin
            count_in    = '0;
            esc_in      = 1'b0;
            broken_in   = 1'b0;
            ended_in    = 1'b0;
            has_star_in = 1'b0;
            star_end_in = 1'b0;
            too_long_in = 1'b0;
            closed_in   = 1'b0;
         end
         wr.clear = closed_ff;
         wr_addr  = count_in;
         if (!ended_in) begin
            if (data_byte == sgm_pkg::CH_NUL) begin
               ended_in = 1'b1;
               if (esc_in) begin
                  broken_in = 1'b1;
               end
               esc_in = 1'b0;
            end else begin
               // any non-NUL byte after the first star moves it off the end
               if (has_star_in) begin
                  star_end_in = 1'b0;
               end
               if (esc_in) begin
                  append = 1'b1;
                  esc_in = 1'b0;
               end else if (data_byte == sgm_pkg::CH_ESC) begin
                  esc_in = 1'b1;
               end else if (data_byte == sgm_pkg::CH_STAR) begin
                  if (!has_star_in) begin
                     has_star_in = 1'b1;
                     star_end_in = 1'b1;
                  end
                  append  = 1'b1;
                  wr.star = 1'b1;
               end else begin
                  append = 1'b1;
               end
            end
         end
         if (append) begin
            if (count_in < CW'(PATTERN_MAX)) begin
               wr.en    = 1'b1;
               count_in = count_in + CW'(1);
            end else begin
               too_long_in = 1'b1;
            end
         end
         if (last) begin
            if (esc_in) begin
               broken_in = 1'b1;
            end
            esc_in    = 1'b0;
            ended_in  = 1'b0;
            closed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         esc_ff      <= 1'b0;
         broken_ff   <= 1'b0;
         ended_ff    <= 1'b0;
         has_star_ff <= 1'b0;
         star_end_ff <= 1'b0;
         too_long_ff <= 1'b0;
         closed_ff   <= 1'b1;
      end else begin
         count_ff    <= count_in;
         esc_ff      <= esc_in;
         broken_ff   <= broken_in;
         ended_ff    <= ended_in;
         has_star_ff <= has_star_in;
         star_end_ff <= star_end_in;
         too_long_ff <= too_long_in;
         closed_ff   <= closed_in;
      end
   end

   assign count = count_ff;

   assign pat_state.has_star      = has_star_ff;
   assign pat_state.star_end_only = star_end_ff;
   assign pat_state.broken        = broken_ff;
   assign pat_state.too_long      = too_long_ff;
   assign pat_state.escape        = esc_ff;

   assign pat_rsp.result_kind   = sgm_pkg::KIND_CLASSIFY;
   assign pat_rsp.has_star      = has_star_in;
   assign pat_rsp.star_end_only = star_end_in;
   assign pat_rsp.matched       = 1'b0;
   assign pat_rsp.overflow      = too_long_in;

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PATTERN_MAX))
      else $error("element count beyond store depth");

   star_end_needs_star: assert property (@(posedge clock) disable iff (reset)
      star_end_ff |-> has_star_ff)
      else $error("star-at-end flag without a star");

   classify_on_last: assert property (@(posedge clock) disable iff (reset)
      pat_accept && last |=> closed_ff && !esc_ff && !ended_ff)
      else $error("pattern not closed after its last byte");

endmodule

// ----- rtl/core/star_glob_matcher.sv -----
// ----------------------------------------------------------------------------
// star_glob_matcher
// Star-only glob matcher: loads a pattern byte by byte into a row of element
// cells, then streams candidate bytes through the active-position vector.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, pattern or candidate, back to back while
//    req_chan is ready. A result is registered into the output register that
//    drives rsp_chan, or into the skid entry while that one is held; the buffer
//    holds req_chan ready until both entries hold results that rsp_chan has not taken.
// The per-byte path is the cell byte compare plus a log2(PATTERN_MAX+1)
//    level star closure network.
// Reset (synchronous): star marks, counts and flags clear, only position zero
//    is active; the element bytes are not cleared.
// ----------------------------------------------------------------------------
module star_glob_matcher #(
   parameter int PATTERN_MAX = 64
) (
   input  logic       clock,
   input  logic       reset,
   sgm_req_if.sink    req_chan,
   sgm_rsp_if.source  rsp_chan
);

   localparam int CW   = $clog2(PATTERN_MAX + 1);
   localparam int NPOS = PATTERN_MAX + 1;

   logic accept;
   logic pat_accept;
   logic cand_accept;
   logic advance;
   logic restart;
   logic push;
   logic pop;

   logic [CW-1:0]              count;
   logic [CW-1:0]              wr_addr;
   sgm_pkg::sgm_wr_type        wr;
   sgm_pkg::sgm_pat_state_type pat_state;
   sgm_pkg::sgm_rsp_type       pat_rsp;
   sgm_pkg::sgm_rsp_type       verdict;
   sgm_pkg::sgm_rsp_type       rsp_new;
   sgm_pkg::sgm_cell_ctrl_type ctrl;

   logic [PATTERN_MAX-1:0] star_nx;
   logic [PATTERN_MAX-1:0] pass;
   logic [NPOS-1:0]        adv_vec;
   logic [NPOS-1:0]        adv_closed;
   logic [NPOS-1:0]        home_closed;
   logic [NPOS-1:0]        act_next;

   logic act_last_ff;
   logic cand_ended_ff, cand_ended_in;

   sgm_pkg::sgm_rsp_type out_ff,  out_in;
   sgm_pkg::sgm_rsp_type skid_ff, skid_in;
   logic out_valid_ff,  out_valid_in;
   logic skid_valid_ff, skid_valid_in;

   assign req_chan.ready = ~skid_valid_ff;
   assign accept      = req_chan.valid & req_chan.ready;
   assign pat_accept  = accept & (req_chan.opcode == sgm_pkg::OP_PATTERN);
   assign cand_accept = accept & (req_chan.opcode == sgm_pkg::OP_CANDIDATE);
   assign advance     = cand_accept & ~cand_ended_ff
                        & (req_chan.data_byte != sgm_pkg::CH_NUL);
   assign restart     = (pat_accept & wr.clear) | (cand_accept & req_chan.last);

   sgm_parser #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .pat_accept (pat_accept),
      .data_byte  (req_chan.data_byte),
      .last       (req_chan.last),
      .count      (count),
      .wr_addr    (wr_addr),
      .wr         (wr),
      .pat_state  (pat_state),
      .pat_rsp    (pat_rsp)
   );

   assign ctrl.advance   = advance;
   assign ctrl.clear     = wr.clear;
   assign ctrl.data_byte = req_chan.data_byte;

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      sgm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_sel   (wr.en && (wr_addr == CW'(i))),
         .wr_star  (wr.star),
         .in_use   (CW'(i) < count),
         .origin   (i == 0),
         .pass_in  ((i == 0) ? 1'b0 : pass[(i == 0) ? 0 : i-1]),
         .act_in   (act_next[i]),
         .star_nx  (star_nx[i]),
         .adv      (adv_vec[i]),
         .pass_out (pass[i])
      );
   end

   // final position has no element, it only collects the last handoff
   assign adv_vec[PATTERN_MAX] = advance ? pass[PATTERN_MAX-1] : act_last_ff;

   sgm_closure #(
      .WIDTH (NPOS)
   ) u_adv_closure (
      .vec    (adv_vec),
      .star   (star_nx),
      .closed (adv_closed)
   );

   sgm_closure #(
      .WIDTH (NPOS)
   ) u_home_closure (
      .vec    (NPOS'(1)),
      .star   (star_nx),
      .closed (home_closed)
   );

   // keep the stored vector closed over the star marks of the next cycle
   assign act_next = restart ? home_closed : adv_closed;

   always_comb begin
      cand_ended_in = cand_ended_ff;
      if (cand_accept) begin
         if (req_chan.last) begin
            cand_ended_in = 1'b0;
         end else if (req_chan.data_byte == sgm_pkg::CH_NUL) begin
            cand_ended_in = 1'b1;
         end
      end else if (pat_accept && wr.clear) begin
         cand_ended_in = 1'b0;
      end
   end

   assign verdict.result_kind   = sgm_pkg::KIND_VERDICT;
   assign verdict.has_star      = pat_state.has_star;
   assign verdict.star_end_only = pat_state.star_end_only;
   assign verdict.matched       = adv_closed[count] & ~pat_state.broken
                                  & ~pat_state.too_long & ~pat_state.escape;
   assign verdict.overflow      = pat_state.too_long;

   assign rsp_new = pat_accept ? pat_rsp : verdict;
   assign push    = accept & req_chan.last;
   assign pop     = out_valid_ff & rsp_chan.ready;

   // output register plus skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = rsp_new;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_last_ff   <= 1'b0;
         cand_ended_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         act_last_ff   <= act_next[PATTERN_MAX];
         cand_ended_ff <= cand_ended_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_kind   = out_ff.result_kind;
   assign rsp_chan.has_star      = out_ff.has_star;
   assign rsp_chan.star_end_only = out_ff.star_end_only;
   assign rsp_chan.matched       = out_ff.matched;
   assign rsp_chan.overflow      = out_ff.overflow;

   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   overflow_never_matches: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.overflow |-> !out_ff.matched)
      else $error("match reported for an overflowed pattern");

   classify_never_matches: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.result_kind == sgm_pkg::KIND_CLASSIFY) |-> !out_ff.matched)
      else $error("classification carries a match");

   origin_after_verdict: assert property (@(posedge clock) disable iff (reset)
      cand_accept && req_chan.last |=> !cand_ended_ff)
      else $error("candidate end mark survived a verdict");

endmodule
